// ----- hw/rtl/bdlp_pkg.sv -----
// Package for the button debouncer: register codes, reset values, shared types.
package bdlp_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned NowWidth         = 32;
  localparam int unsigned DebWidth         = 16;
  localparam int unsigned LongWidth        = 32;
  localparam int unsigned CfgDataWidth     = 32;
  localparam int unsigned CfgIdxWidth      = 2;

  localparam logic [DebWidth-1:0]  DebounceReset  = DebWidth'(5);
  localparam logic [LongWidth-1:0] LongPressReset = '0;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDebounce  = 2'd0,
    CfgLongTicks = 2'd1,
    CfgPressEn   = 2'd2,
    CfgLongEn    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DebWidth-1:0]  debounce_ticks;
    logic [LongWidth-1:0] long_press_ticks;
    logic                 press_enable;
    logic                 long_press_enable;
  } cfg_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic held;
  } res_t;

endpackage

// ----- hw/rtl/bdlp_core.sv -----
// Debounce state and per-sample press/release decision logic.
module bdlp_core import bdlp_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                level_i,
  input  logic [NowWidth-1:0] now_i,
  input  cfg_t                cfg_i,
  output res_t                res_o
);

  // compare width covers the elapsed time and both thresholds
  localparam int unsigned CmpW = (TIME_WIDTH > LongWidth) ? TIME_WIDTH : LongWidth;

  logic                  prev_level_q, prev_level_d;
  logic [TIME_WIDTH-1:0] fall_time_q, fall_time_d;
  logic [TIME_WIDTH-1:0] press_time_q, press_time_d;
  logic [TIME_WIDTH-1:0] rise_time_q, rise_time_d;
  logic                  pending_q, pending_d;
  logic                  pressed_q, pressed_d;
  logic                  long_sent_q, long_sent_d;

  logic [CmpW-1:0]       now_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic                  falling, rising;
  logic [TIME_WIDTH-1:0] el_fall, el_press, el_rise;
  logic [CmpW-1:0]       deb_ext, long_ext;
  logic                  accept, pressed_mid, long_mid, long_ev, release_ev;
  logic [TIME_WIDTH-1:0] press_mid;

  assign now_ext = CmpW'(now_i);
  assign now_t   = now_ext[TIME_WIDTH-1:0];
  assign deb_ext  = CmpW'(cfg_i.debounce_ticks);
  assign long_ext = CmpW'(cfg_i.long_press_ticks);

  assign falling = prev_level_q && !level_i;
  assign rising  = !prev_level_q && level_i;

  always_comb begin
    fall_time_d = falling ? now_t : fall_time_q;
    rise_time_d = rising ? now_t : rise_time_q;
    pending_d   = rising ? 1'b1 : (falling ? 1'b0 : pending_q);

    el_fall  = now_t - fall_time_d;
    el_press = now_t - press_time_q;
    accept   = !level_i && !pressed_q && (CmpW'(el_fall) >= deb_ext) &&
               (CmpW'(el_press) > deb_ext);

    pressed_mid = pressed_q || accept;
    press_mid   = accept ? now_t : press_time_q;
    long_mid    = accept ? 1'b0 : long_sent_q;

    long_ev = pressed_mid && !level_i && !long_mid && (long_ext != '0) &&
              cfg_i.long_press_enable && (CmpW'(TIME_WIDTH'(now_t - press_mid)) >= long_ext);

    el_rise    = now_t - rise_time_d;
    release_ev = level_i && pressed_mid && pending_d && (CmpW'(el_rise) >= deb_ext);

    press_time_d = press_mid;
    pressed_d    = pressed_mid && !release_ev;
    long_sent_d  = (long_mid || long_ev) && !release_ev;
    if (release_ev) begin
      pending_d = 1'b0;
    end
    prev_level_d = level_i;

    res_o.short_press = release_ev && !long_mid && cfg_i.press_enable;
    res_o.long_press  = long_ev;
    res_o.held        = pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b1;
      fall_time_q  <= '0;
      press_time_q <= '0;
      rise_time_q  <= '0;
      pending_q    <= 1'b0;
      pressed_q    <= 1'b0;
      long_sent_q  <= 1'b0;
    end else if (step_i) begin
      prev_level_q <= prev_level_d;
      fall_time_q  <= fall_time_d;
      press_time_q <= press_time_d;
      rise_time_q  <= rise_time_d;
      pending_q    <= pending_d;
      pressed_q    <= pressed_d;
      long_sent_q  <= long_sent_d;
    end
  end

endmodule

// ----- hw/rtl/button_debounce_long_press.sv -----
// Top level of the debounced active-low button with short and long press events.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one beat per pin sample:
//   level_i (0 = pressed) and now_i, the free-running tick time of the sample.
//   Output channel (out_valid_o/out_ready_i) returns exactly one beat per input
//   beat, in order: short_press_o, long_press_o and the debounced held_o.
//   The result beat passes two registers: the accepting edge puts the
//   sample in the input register, and the decision against the debounce state
//   is captured in the output register once that register is free or drains.
//   Throughput is one beat per cycle while the receiver keeps out_ready_i high,
//   set by the combinational subtract-and-compare path in bdlp_core.
//   When the receiver stalls, the output register holds its beat and the input
//   register takes one more; in_ready_o drops only when both are full.
//   Reset clears both stages and the state to "released, nothing pending";
//   registers return to debounce 5, long press 0 (off), both enables off.
//   Config writes (cfg_we_i) take effect at once and should only happen while
//   no beat is in flight.
module button_debounce_long_press import bdlp_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    level_i,
  input  logic [NowWidth-1:0]     now_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    short_press_o,
  output logic                    long_press_o,
  output logic                    held_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  cfg_t cfg_q;

  // input stage
  logic                in_v_q;
  logic                in_level_q;
  logic [NowWidth-1:0] in_now_q;

  // output stage
  logic out_v_q;
  res_t out_q;
  res_t res;
  logic advance;

  // stage 1 moves into the output register when that register is free or drains
  assign advance    = in_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !in_v_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks    <= DebounceReset;
      cfg_q.long_press_ticks  <= LongPressReset;
      cfg_q.press_enable      <= 1'b0;
      cfg_q.long_press_enable <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgDebounce:  cfg_q.debounce_ticks    <= cfg_wdata_i[DebWidth-1:0];
        CfgLongTicks: cfg_q.long_press_ticks  <= cfg_wdata_i[LongWidth-1:0];
        CfgPressEn:   cfg_q.press_enable      <= cfg_wdata_i[0];
        CfgLongEn:    cfg_q.long_press_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_level_q <= level_i;
      in_now_q   <= now_i;
    end
  end

  bdlp_core #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .level_i(in_level_q),
    .now_i  (in_now_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_v_q;
  assign short_press_o = out_q.short_press;
  assign long_press_o  = out_q.long_press;
  assign held_o        = out_q.held;

  // a release needs a high sample, a long press a low one
  a_no_double_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(out_q.short_press && out_q.long_press))
    else $error("short and long press in the same beat");

  a_short_clears_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.short_press) |-> !out_q.held)
    else $error("short press while still held");

  a_long_keeps_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.long_press) |-> out_q.held)
    else $error("long press without held");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_v_q && out_v_q && !out_ready_i))
    else $error("input stalled with room in the pipe");

endmodule
